[design/rra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rra_pkg;

  localparam int unsigned CLIENT_W = 16;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned ID_W     = 5;
  localparam int unsigned USE_W    = 16;

  localparam logic [ID_W-1:0]  ACTIVE_RESET = 5'd16;
  localparam logic [USE_W-1:0] USE_MAX      = 16'hFFFF;

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_NONE      = 2'd1,
    STAT_RELEASED  = 2'd2,
    STAT_UNKNOWN   = 2'd3
  } status_e;

  typedef struct packed {
    logic                operation;
    logic [CLIENT_W-1:0] client_id;
    logic [ENTRY_W-1:0]  entry_id;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   granted_id;
    logic [USE_W-1:0]  use_total;
    logic [ID_W-1:0]   free_total;
  } rsp_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] holder;
    logic [USE_W-1:0]    uses;
  } entry_t;

endpackage

`default_nettype wire

[design/round_robin_resource_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Round-robin allocator over a pool of entries with ids 1..active_count (capped at
// POOL_SIZE and at 31). A beat on start while busy is low is taken; the result is
// registered after the execute cycle and shown on rsp_o for one cycle with
// rsp_valid_o, and cannot be held off. The accept cycle runs the round-robin search
// over the free bitmap and issues the read of the entry memory, the next cycle
// writes the entry back and updates bitmap and pointer. busy is low again in the
// cycle the result is shown, so a new item is taken only once the last is through.
// A write of active_count sets busy while the search pointer is reduced modulo
// the new count by a one-bit-per-cycle remainder unit.
module round_robin_resource_allocator #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  rra_pkg::req_t    req_i,
  input  wire              cfg_we_i,
  input  wire [4:0]        cfg_wdata_i,
  output logic             rsp_valid_o,
  output rra_pkg::rsp_t    rsp_o
);
  import rra_pkg::*;

  localparam int unsigned LIVE_MAX = (POOL_SIZE < 31) ? POOL_SIZE : 31;
  localparam int unsigned IDX_W    = (LIVE_MAX > 1) ? $clog2(LIVE_MAX) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_NORM
  } state_e;

  state_e              state_q;
  logic [ID_W-1:0]     active_q;
  logic [LIVE_MAX-1:0] free_q, free_d;
  logic [ID_W-1:0]     search_q, start_q;
  logic [ID_W-1:0]     rem_q, rem_d;
  logic [2:0]          step_q;
  logic                op_q, hit_q;
  logic [CLIENT_W-1:0] client_q;
  logic [ID_W-1:0]     idx_q;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_valid_q;

  entry_t              mem_q [LIVE_MAX];
  logic [LIVE_MAX-1:0] written_q;
  entry_t              rdata_q;
  logic                rvalid_q;

  logic [ID_W-1:0]     n_eff;
  logic [LIVE_MAX-1:0] act_mask, hi_mask, hi_free, all_free;
  logic [ID_W-1:0]     hi_idx, all_idx, grant_idx, sel_idx, next_ptr;
  logic                hi_found, all_found, grant_hit, rel_hit, sel_hit;
  logic                accept;
  logic [USE_W-1:0]    uses_old, uses_new;
  logic [ID_W-1:0]     free_cnt;
  logic [ID_W:0]       rem_t;
  logic [2:0]          bit_sel;

  assign n_eff  = (active_q > ID_W'(LIVE_MAX)) ? ID_W'(LIVE_MAX) : active_q;
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // rotated first-free search over the active entries
  always_comb begin
    hi_found  = 1'b0;
    all_found = 1'b0;
    hi_idx    = '0;
    all_idx   = '0;
    for (int i = 0; i < LIVE_MAX; i++) begin
      act_mask[i] = (ID_W'(i) < n_eff);
      hi_mask[i]  = act_mask[i] && (ID_W'(i) >= start_q);
    end
    hi_free  = free_q & hi_mask;
    all_free = free_q & act_mask;
    for (int i = LIVE_MAX - 1; i >= 0; i--) begin
      if (hi_free[i]) begin
        hi_found = 1'b1;
        hi_idx   = ID_W'(i);
      end
      if (all_free[i]) begin
        all_found = 1'b1;
        all_idx   = ID_W'(i);
      end
    end
    grant_hit = all_found;
    grant_idx = hi_found ? hi_idx : all_idx;
    rel_hit   = (req_i.entry_id != '0) &&
                (req_i.entry_id <= {{(ENTRY_W-ID_W){1'b0}}, n_eff});
    if (req_i.operation == OP_ALLOCATE) begin
      sel_hit = grant_hit;
      sel_idx = grant_idx;
    end else begin
      sel_hit = rel_hit;
      sel_idx = ID_W'(req_i.entry_id - 8'd1);
    end
  end

  // entry update, result and free count
  always_comb begin
    uses_old = rvalid_q ? rdata_q.uses : '0;
    uses_new = (uses_old == USE_MAX) ? USE_MAX : uses_old + 16'd1;
    next_ptr = (idx_q + 5'd1 == n_eff) ? '0 : idx_q + 5'd1;
    free_d   = free_q;
    for (int i = 0; i < LIVE_MAX; i++) begin
      if (hit_q && ID_W'(i) == idx_q) begin
        free_d[i] = (op_q == OP_RELEASE);
      end
    end
    free_cnt = '0;
    for (int i = 0; i < LIVE_MAX; i++) begin
      free_cnt = free_cnt + ID_W'(free_d[i] & act_mask[i]);
    end
    rsp_d            = '0;
    rsp_d.free_total = free_cnt;
    if (op_q == OP_ALLOCATE) begin
      if (hit_q) begin
        rsp_d.status     = STAT_ALLOCATED;
        rsp_d.granted_id = idx_q + 5'd1;
      end else begin
        rsp_d.status = STAT_NONE;
      end
    end else begin
      if (hit_q) begin
        rsp_d.status    = STAT_RELEASED;
        rsp_d.use_total = uses_new;
      end else begin
        rsp_d.status = STAT_UNKNOWN;
      end
    end
  end

  // restoring remainder step: search pointer modulo the active count
  always_comb begin
    bit_sel = 3'(ID_W - 1) - step_q;
    rem_t   = {rem_q, search_q[bit_sel]};
    if (rem_t >= {1'b0, n_eff}) begin
      rem_t = rem_t - {1'b0, n_eff};
    end
    rem_d = rem_t[ID_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_RESET;
      free_q      <= '1;
      search_q    <= '0;
      start_q     <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      op_q        <= OP_ALLOCATE;
      hit_q       <= 1'b0;
      client_q    <= '0;
      idx_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= (state_q == S_EXEC) && !cfg_we_i;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
        rem_q    <= '0;
        step_q   <= '0;
        state_q  <= S_NORM;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (accept) begin
              op_q     <= req_i.operation;
              client_q <= req_i.client_id;
              hit_q    <= sel_hit;
              idx_q    <= sel_idx;
              state_q  <= S_EXEC;
            end
          end
          S_EXEC: begin
            free_q <= free_d;
            rsp_q  <= rsp_d;
            if (hit_q && op_q == OP_ALLOCATE) begin
              search_q <= next_ptr;
              start_q  <= next_ptr;
            end
            state_q <= S_IDLE;
          end
          S_NORM: begin
            rem_q  <= rem_d;
            step_q <= step_q + 3'd1;
            if (n_eff == '0) begin
              state_q <= S_IDLE;
            end else if (step_q == 3'(ID_W - 1)) begin
              start_q <= rem_d;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  // entry memory: read on accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[sel_idx[IDX_W-1:0]];
    end
    if (state_q == S_EXEC && hit_q && !cfg_we_i) begin
      if (op_q == OP_ALLOCATE) begin
        mem_q[idx_q[IDX_W-1:0]] <= '{holder: client_q, uses: uses_old};
      end else begin
        mem_q[idx_q[IDX_W-1:0]] <= '{holder: '0, uses: uses_new};
      end
    end
  end

  // use counts read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (accept) begin
        rvalid_q <= written_q[sel_idx[IDX_W-1:0]];
      end
      if (state_q == S_EXEC && hit_q && !cfg_we_i) begin
        written_q[idx_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_rsp_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q) == S_EXEC)
    else $error("result strobe without a preceding execute cycle");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == STAT_ALLOCATED) |->
      (rsp_o.granted_id != '0 && rsp_o.granted_id <= n_eff))
    else $error("granted id outside the active entries");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.free_total <= n_eff)
    else $error("free count exceeds active count");

  a_ptr_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && n_eff != '0) |-> start_q < n_eff)
    else $error("search start not reduced below active count");
`endif

endmodule

`default_nettype wire
